@@ rtl/scc_pkg.sv @@
package scc_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int REG_COUNT = 16;

  localparam logic [15:0] RESET_VECTOR = 16'hfffe;
  localparam logic [15:0] FLAG_MASK = 16'h0107;

  localparam logic [3:0] REG_PC = 4'd0;
  localparam logic [3:0] REG_SP = 4'd1;
  localparam logic [3:0] REG_SR = 4'd2;
  localparam logic [3:0] REG_CG = 4'd3;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SETREG = 2'd1,
    MODE_RESET  = 2'd2,
    MODE_EXEC   = 2'd3
  } mode_e;

  // single-operand codes
  localparam logic [2:0] SC_RRC  = 3'd0;
  localparam logic [2:0] SC_SWPB = 3'd1;
  localparam logic [2:0] SC_RRA  = 3'd2;
  localparam logic [2:0] SC_SXT  = 3'd3;
  localparam logic [2:0] SC_PUSH = 3'd4;
  localparam logic [2:0] SC_CALL = 3'd5;
  localparam logic [2:0] SC_RETI = 3'd6;

  // double-operand codes
  localparam logic [3:0] DO_MOV  = 4'd4;
  localparam logic [3:0] DO_ADD  = 4'd5;
  localparam logic [3:0] DO_ADDC = 4'd6;
  localparam logic [3:0] DO_SUBC = 4'd7;
  localparam logic [3:0] DO_SUB  = 4'd8;
  localparam logic [3:0] DO_CMP  = 4'd9;
  localparam logic [3:0] DO_DADD = 4'd10;
  localparam logic [3:0] DO_BIT  = 4'd11;
  localparam logic [3:0] DO_BIC  = 4'd12;
  localparam logic [3:0] DO_BIS  = 4'd13;
  localparam logic [3:0] DO_XOR  = 4'd14;
  localparam logic [3:0] DO_AND  = 4'd15;

  typedef enum logic [4:0] {
    DP_NOP, DP_CLR, DP_LATCH, DP_LOAD_WR, DP_SETREG, DP_CORE_RST, DP_RST_PC,
    DP_RD_LO, DP_RD_HI, DP_RD_END, DP_FETCH, DP_DECODE, DP_ERR, DP_PC_INC,
    DP_OPA, DP_OPX, DP_OPV, DP_EXEC, DP_WB_REG, DP_WR_LO, DP_WR_HI,
    DP_SP_DEC, DP_CALL_PC, DP_RETI_A, DP_RETI_B, DP_RETI_C, DP_RESP
  } dp_op_e;

  typedef enum logic [1:0] {
    OPK_IMM, OPK_EXT, OPK_MEM
  } opk_e;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD, S_SETREG, S_CRST, S_RSTPC, S_FETCH,
    S_RD0, S_RD1, S_RD2, S_DECODE, S_CHECK, S_OPA, S_OPX, S_OPV,
    S_EXEC, S_WB, S_WR0, S_WR1, S_SPDEC, S_CALLPC,
    S_RETI0, S_RETI1, S_RETI2, S_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic       invalid;
    logic       is_jump;
    logic       is_single;
    logic       is_double;
    logic [2:0] scode;
    logic       opsel;
    opk_e       opk;
    logic       wb_reg;
    logic       wb_mem;
    logic       mem_byte;
    logic       clr_done;
    logic       out_free;
  } dp_status_t;

endpackage

@@ rtl/sixteen_bit_cpu_core_step.sv @@
// Sequence: load byte and set register perform their write and then respond; core reset
//   loads the reset vector into the PC; execute fetches, decodes, reads operands as needed,
//   executes and writes back. Throughput: one item at a time; the next item is accepted once
//   the result is registered. Each memory word passes a byte at a time through the single byte-wide memory port.
// Reset: registers to 0xffff, instruction address to zero, then a clearing pass writes 0xff
//   to all MEM_BYTES memory bytes while no item is accepted.
module sixteen_bit_cpu_core_step import scc_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] address_i,
  input  logic [15:0] data_i,
  input  logic [3:0]  reg_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pc_o,
  output logic [15:0] status_reg_o,
  output logic [15:0] insn_address_o,
  output logic        error_o
);

  dp_status_t status;
  dp_op_e     op;

  scc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .mode_i    (mode_i),
    .status_i  (status),
    .in_stall_o(in_stall_o),
    .op_o      (op)
  );

  scc_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .address_i     (address_i),
    .data_i        (data_i),
    .reg_index_i   (reg_index_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pc_o          (pc_o),
    .status_reg_o  (status_reg_o),
    .insn_address_o(insn_address_o),
    .error_o       (error_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted request did not start work");

  a_err_pc_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> pc_o == insn_address_o)
    else $error("invalid opcode moved the PC");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in work");

endmodule

@@ rtl/scc_ram.sv @@
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/scc_ctrl.sv @@
module scc_ctrl import scc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  input  dp_status_t status_i,
  output logic       in_stall_o,
  output dp_op_e     op_o
);

  ctrl_state_e state_q, state_d;
  ctrl_state_e ret_q, ret_d;
  ctrl_state_e after_opnd;
  ctrl_state_e after_exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    after_opnd = (status_i.is_double && !status_i.opsel) ? S_OPA : S_EXEC;
    if (status_i.is_jump) begin
      after_exec = S_RESP;
    end else if (status_i.is_single &&
                 (status_i.scode == SC_PUSH || status_i.scode == SC_CALL)) begin
      after_exec = S_SPDEC;
    end else if (status_i.is_single && status_i.scode == SC_RETI) begin
      after_exec = S_RETI0;
    end else if (status_i.wb_reg) begin
      after_exec = S_WB;
    end else if (status_i.wb_mem) begin
      after_exec = S_WR0;
    end else begin
      after_exec = S_RESP;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    op_o    = DP_NOP;
    unique case (state_q)
      S_CLR: begin
        op_o = DP_CLR;
        if (status_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = DP_LATCH;
          unique case (mode_e'(mode_i))
            MODE_LOAD:   state_d = S_LOAD;
            MODE_SETREG: state_d = S_SETREG;
            MODE_RESET:  state_d = S_CRST;
            MODE_EXEC:   state_d = S_FETCH;
            default:     state_d = S_FETCH;
          endcase
        end
      end
      S_LOAD: begin
        op_o    = DP_LOAD_WR;
        state_d = S_RESP;
      end
      S_SETREG: begin
        op_o    = DP_SETREG;
        state_d = S_RESP;
      end
      S_CRST: begin
        op_o    = DP_CORE_RST;
        ret_d   = S_RSTPC;
        state_d = S_RD0;
      end
      S_RSTPC: begin
        op_o    = DP_RST_PC;
        state_d = S_RESP;
      end
      S_FETCH: begin
        op_o    = DP_FETCH;
        ret_d   = S_DECODE;
        state_d = S_RD0;
      end
      S_RD0: begin
        op_o    = DP_RD_LO;
        state_d = S_RD1;
      end
      S_RD1: begin
        op_o    = DP_RD_HI;
        state_d = S_RD2;
      end
      S_RD2: begin
        op_o    = DP_RD_END;
        state_d = ret_q;
      end
      S_DECODE: begin
        op_o    = DP_DECODE;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.invalid) begin
          op_o    = DP_ERR;
          state_d = S_RESP;
        end else begin
          op_o    = DP_PC_INC;
          state_d = status_i.is_jump ? S_EXEC : S_OPA;
        end
      end
      S_OPA: begin
        op_o = DP_OPA;
        unique case (status_i.opk)
          OPK_IMM: state_d = after_opnd;
          OPK_EXT: begin
            ret_d   = S_OPX;
            state_d = S_RD0;
          end
          default: begin
            ret_d   = S_OPV;
            state_d = S_RD0;
          end
        endcase
      end
      S_OPX: begin
        op_o    = DP_OPX;
        ret_d   = S_OPV;
        state_d = S_RD0;
      end
      S_OPV: begin
        op_o    = DP_OPV;
        state_d = after_opnd;
      end
      S_EXEC: begin
        op_o    = DP_EXEC;
        state_d = after_exec;
      end
      S_WB: begin
        op_o    = DP_WB_REG;
        state_d = S_RESP;
      end
      S_WR0: begin
        op_o    = DP_WR_LO;
        state_d = status_i.mem_byte ? S_RESP : S_WR1;
      end
      S_WR1: begin
        op_o    = DP_WR_HI;
        state_d = (status_i.is_single && status_i.scode == SC_CALL) ? S_CALLPC : S_RESP;
      end
      S_SPDEC: begin
        op_o    = DP_SP_DEC;
        state_d = S_WR0;
      end
      S_CALLPC: begin
        op_o    = DP_CALL_PC;
        state_d = S_RESP;
      end
      S_RETI0: begin
        op_o    = DP_RETI_A;
        ret_d   = S_RETI1;
        state_d = S_RD0;
      end
      S_RETI1: begin
        op_o    = DP_RETI_B;
        ret_d   = S_RETI2;
        state_d = S_RD0;
      end
      S_RETI2: begin
        op_o    = DP_RETI_C;
        state_d = S_RESP;
      end
      S_RESP: begin
        op_o = DP_RESP;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ rtl/scc_dp.sv @@
module scc_dp import scc_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_op_e      op_i,
  input  logic [15:0] address_i,
  input  logic [15:0] data_i,
  input  logic [3:0]  reg_index_i,
  output dp_status_t  status_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pc_o,
  output logic [15:0] status_reg_o,
  output logic [15:0] insn_address_o,
  output logic        error_o
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [22:0] RECIP =
    23'(((64'd1 << 32) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES));

  // reduce an address modulo the memory size by reciprocal multiply
  function automatic logic [AW-1:0] mem_loc(input logic [15:0] a);
    logic [38:0] prod;
    logic [6:0]  quo;
    logic [22:0] qm;
    logic [16:0] rem;
    prod = {23'd0, a} * {16'd0, RECIP};
    quo  = prod[38:32];
    qm   = 23'(quo) * 23'(MEM_BYTES);
    rem  = {1'b0, a} - qm[16:0];
    return rem[AW-1:0];
  endfunction

  logic [15:0] rf_q [REG_COUNT];
  logic [15:0] addr_q, data_q, mar_q, mdr_q, ir_q, src_q, dst_q, ea_q, res_q;
  logic [3:0]  ri_q;
  logic        tm_q, opsel_q, err_q;
  logic [15:0] insn_q;
  logic [AW:0] clr_cnt_q;
  logic        out_valid_q;
  logic [15:0] pc_out_q, sr_out_q, insn_out_q;
  logic        err_out_q;

  // decode
  logic        is_jump, is_single, is_double, invalid, byte_op;
  logic [1:0]  am_cur;
  logic [3:0]  r_cur;
  logic [15:0] mask, msb, rf_rd;
  logic        cg_hit;
  logic [15:0] cg_val, imm_val, inc_val;
  opk_e        opk;
  logic        needs_wb;
  logic        clr_done;
  logic        out_free;

  assign is_jump   = (ir_q[15:13] == 3'b001);
  assign is_single = (ir_q[15:13] == 3'b000);
  assign is_double = (ir_q[15:14] != 2'b00);
  assign invalid   = is_single && ((ir_q[15:10] != 6'b000100) || (ir_q[9:7] == 3'd7));
  assign byte_op   = ir_q[6];
  assign mask      = byte_op ? 16'h00ff : 16'hffff;
  assign msb       = byte_op ? 16'h0080 : 16'h8000;
  assign am_cur    = (is_double && opsel_q) ? {1'b0, ir_q[7]} : ir_q[5:4];
  assign r_cur     = (is_double && !opsel_q) ? ir_q[11:8] : ir_q[3:0];
  assign rf_rd     = rf_q[r_cur];
  assign inc_val   = (byte_op && r_cur > REG_SP) ? 16'd1 : 16'd2;

  always_comb begin
    cg_hit = 1'b0;
    cg_val = 16'd0;
    unique case (am_cur)
      2'd0: begin
        cg_hit = (r_cur == REG_CG);
        cg_val = 16'd0;
      end
      2'd1: begin
        cg_hit = (r_cur == REG_CG);
        cg_val = 16'd1;
      end
      2'd2: begin
        cg_hit = (r_cur == REG_SR) || (r_cur == REG_CG);
        cg_val = (r_cur == REG_SR) ? 16'd4 : 16'd2;
      end
      default: begin
        cg_hit = (r_cur == REG_SR) || (r_cur == REG_CG);
        cg_val = (r_cur == REG_SR) ? 16'd8 : mask;
      end
    endcase
    imm_val = cg_hit ? cg_val : (rf_rd & mask);
    if (cg_hit || am_cur == 2'd0) opk = OPK_IMM;
    else if (am_cur == 2'd1)      opk = OPK_EXT;
    else                          opk = OPK_MEM;
  end

  assign needs_wb = is_double ? (ir_q[15:12] != DO_CMP && ir_q[15:12] != DO_BIT)
                              : (ir_q[9:7] <= SC_SXT);
  assign clr_done = (clr_cnt_q == (AW+1)'(MEM_BYTES));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o.invalid   = invalid;
    status_o.is_jump   = is_jump;
    status_o.is_single = is_single;
    status_o.is_double = is_double;
    status_o.scode     = ir_q[9:7];
    status_o.opsel     = opsel_q;
    status_o.opk       = opk;
    status_o.wb_reg    = needs_wb && (am_cur == 2'd0);
    status_o.wb_mem    = needs_wb && (am_cur != 2'd0) && tm_q;
    status_o.mem_byte  = byte_op && !(is_single && ir_q[9]);
    status_o.clr_done  = clr_done;
    status_o.out_free  = out_free;
  end

  // ALU
  logic [16:0] add_s, add_sum;
  logic        cin, cflag;
  logic [4:0]  dsum;
  logic        dcar, dcar_b;
  logic [15:0] dres;
  logic [15:0] alu_res;
  logic        fl_we, fl_c, fl_z, fl_n, fl_v;
  logic        take;
  logic [15:0] sr;

  assign sr    = rf_q[REG_SR];
  assign cflag = sr[0];

  always_comb begin
    add_s  = (ir_q[15:12] >= DO_SUBC) ? {1'b0, ~src_q & mask} : {1'b0, src_q};
    cin    = (ir_q[15:12] == DO_ADDC || ir_q[15:12] == DO_SUBC) ? cflag
           : (ir_q[15:12] >= DO_SUB);
    add_sum = add_s + {1'b0, dst_q} + 17'(cin);

    dcar   = cflag;
    dcar_b = 1'b0;
    dres   = 16'd0;
    for (int i = 0; i < 4; i++) begin
      dsum = {1'b0, src_q[4*i +: 4]} + {1'b0, dst_q[4*i +: 4]} + 5'(dcar);
      if (dsum > 5'd9) begin
        dsum = dsum + 5'd6;
        dcar = 1'b1;
      end else begin
        dcar = 1'b0;
      end
      dres[4*i +: 4] = dsum[3:0];
      if (i == 1) dcar_b = dcar;
    end

    alu_res = 16'd0;
    fl_we = 1'b0;
    fl_c = 1'b0;
    fl_z = 1'b0;
    fl_n = 1'b0;
    fl_v = 1'b0;
    if (is_double) begin
      unique case (ir_q[15:12])
        DO_MOV: alu_res = src_q;
        DO_ADD, DO_ADDC, DO_SUBC, DO_SUB, DO_CMP: begin
          alu_res = add_sum[15:0];
          fl_we = 1'b1;
          fl_c  = byte_op ? add_sum[8] : add_sum[16];
          fl_v  = |(~(add_s[15:0] ^ dst_q) & (add_s[15:0] ^ add_sum[15:0]) & msb);
        end
        DO_DADD: begin
          alu_res = dres;
          fl_we = 1'b1;
          fl_c  = byte_op ? dcar_b : dcar;
        end
        DO_BIT, DO_AND: begin
          alu_res = src_q & dst_q;
          fl_we = 1'b1;
          fl_c  = |(alu_res & mask);
        end
        DO_BIC: alu_res = dst_q & ~src_q;
        DO_BIS: alu_res = dst_q | src_q;
        default: begin
          alu_res = dst_q ^ src_q;
          fl_we = 1'b1;
          fl_c  = |(alu_res & mask);
          fl_v  = |(src_q & dst_q & msb);
        end
      endcase
      fl_z = ((alu_res & mask) == 16'd0);
      fl_n = |(alu_res & msb);
    end else begin
      unique case (ir_q[9:7])
        SC_RRC, SC_RRA: begin
          alu_res = {1'b0, src_q[15:1]};
          if (byte_op) alu_res[7] = (ir_q[9:7] == SC_RRC) ? cflag : src_q[7];
          else alu_res[15] = (ir_q[9:7] == SC_RRC) ? cflag : src_q[15];
          fl_we = 1'b1;
          fl_c  = src_q[0];
          fl_n  = |(alu_res & msb);
        end
        SC_SWPB: alu_res = {src_q[7:0], src_q[15:8]};
        SC_SXT: begin
          alu_res = {{8{src_q[7]}}, src_q[7:0]};
          fl_we = 1'b1;
          fl_c  = |(alu_res & mask);
          fl_n  = src_q[7];
        end
        default: alu_res = src_q;
      endcase
      fl_z = ((alu_res & mask) == 16'd0);
    end

    unique case (ir_q[12:10])
      3'd0: take = !sr[1];
      3'd1: take = sr[1];
      3'd2: take = !sr[0];
      3'd3: take = sr[0];
      3'd4: take = sr[2];
      3'd5: take = (sr[2] == sr[8]);
      3'd6: take = (sr[2] != sr[8]);
      default: take = 1'b1;
    endcase
  end

  // memory port
  logic          ram_we;
  logic [15:0]   ram_vaddr;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_vaddr = mar_q;
    ram_wdata = res_q[7:0];
    ram_addr  = mem_loc(ram_vaddr);
    unique case (op_i)
      DP_CLR: begin
        ram_we    = !clr_done;
        ram_wdata = 8'hff;
      end
      DP_LOAD_WR: begin
        ram_we    = 1'b1;
        ram_vaddr = addr_q;
        ram_wdata = data_q[7:0];
      end
      DP_RD_HI: ram_vaddr = mar_q + 16'd1;
      DP_WR_LO: ram_we = 1'b1;
      DP_WR_HI: begin
        ram_we    = 1'b1;
        ram_vaddr = mar_q + 16'd1;
        ram_wdata = res_q[15:8];
      end
      default: ;
    endcase
    ram_addr = (op_i == DP_CLR) ? clr_cnt_q[AW-1:0] : mem_loc(ram_vaddr);
  end

  scc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) rf_q[i] <= 16'hffff;
      insn_q      <= 16'd0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      opsel_q     <= 1'b0;
    end else begin
      if (op_i == DP_RESP && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (op_i)
        DP_CLR: if (!clr_done) clr_cnt_q <= clr_cnt_q + 1'b1;
        DP_SETREG: rf_q[ri_q] <= data_q;
        DP_CORE_RST: for (int i = 0; i < REG_COUNT; i++) rf_q[i] <= 16'd0;
        DP_RST_PC: rf_q[REG_PC] <= mdr_q;
        DP_FETCH: insn_q <= rf_q[REG_PC];
        DP_PC_INC: begin
          rf_q[REG_PC] <= rf_q[REG_PC] + 16'd2;
          opsel_q      <= 1'b0;
        end
        DP_OPA: begin
          if (opk == OPK_IMM || opk == OPK_MEM) begin
            if (is_double && !opsel_q && opk == OPK_IMM) opsel_q <= 1'b1;
          end
          if (opk == OPK_EXT) rf_q[REG_PC] <= rf_q[REG_PC] + 16'd2;
          if (opk == OPK_MEM && am_cur == 2'd3) rf_q[r_cur] <= rf_rd + inc_val;
        end
        DP_OPV: if (is_double && !opsel_q) opsel_q <= 1'b1;
        DP_EXEC: begin
          if (is_jump) begin
            if (take) rf_q[REG_PC] <= rf_q[REG_PC] + {{5{ir_q[9]}}, ir_q[9:0], 1'b0};
          end else if (fl_we) begin
            rf_q[REG_SR] <= (sr & ~FLAG_MASK) |
                            {7'd0, fl_v, 5'd0, fl_n, fl_z, fl_c};
          end
        end
        DP_WB_REG: rf_q[r_cur] <= res_q;
        DP_SP_DEC: rf_q[REG_SP] <= rf_q[REG_SP] - 16'd2;
        DP_CALL_PC: rf_q[REG_PC] <= src_q;
        DP_RETI_B: begin
          rf_q[REG_SR] <= mdr_q;
          rf_q[REG_SP] <= rf_q[REG_SP] + 16'd2;
        end
        DP_RETI_C: begin
          rf_q[REG_PC] <= mdr_q;
          rf_q[REG_SP] <= rf_q[REG_SP] + 16'd2;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      DP_LATCH: begin
        addr_q <= address_i;
        data_q <= data_i;
        ri_q   <= reg_index_i;
        err_q  <= 1'b0;
      end
      DP_CORE_RST: mar_q <= RESET_VECTOR;
      DP_RD_HI: mdr_q[7:0] <= ram_rdata;
      DP_RD_END: mdr_q[15:8] <= ram_rdata;
      DP_FETCH: mar_q <= rf_q[REG_PC];
      DP_DECODE: ir_q <= mdr_q;
      DP_ERR: err_q <= 1'b1;
      DP_OPA: begin
        if (opk == OPK_IMM) begin
          if (!opsel_q) src_q <= imm_val;
          else dst_q <= imm_val;
          tm_q <= 1'b0;
          ea_q <= 16'd0;
        end else if (opk == OPK_EXT) begin
          mar_q <= rf_q[REG_PC];
        end else begin
          mar_q <= rf_rd;
        end
      end
      DP_OPX: begin
        // indexed: PC-relative uses the extension word's own address
        if (r_cur == REG_SR) mar_q <= mdr_q;
        else if (r_cur == REG_PC) mar_q <= mdr_q + mar_q;
        else mar_q <= mdr_q + rf_rd;
      end
      DP_OPV: begin
        if (!opsel_q) src_q <= mdr_q & mask;
        else dst_q <= mdr_q & mask;
        tm_q <= 1'b1;
        ea_q <= mar_q;
      end
      DP_EXEC: begin
        res_q <= alu_res & mask;
        mar_q <= ea_q;
      end
      DP_SP_DEC: begin
        mar_q <= rf_q[REG_SP] - 16'd2;
        res_q <= (ir_q[9:7] == SC_CALL) ? rf_q[REG_PC] : src_q;
      end
      DP_RETI_A: mar_q <= rf_q[REG_SP];
      DP_RETI_B: mar_q <= rf_q[REG_SP] + 16'd2;
      DP_RESP: begin
        if (out_free) begin
          pc_out_q   <= rf_q[REG_PC];
          sr_out_q   <= rf_q[REG_SR];
          insn_out_q <= insn_q;
          err_out_q  <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign pc_o           = pc_out_q;
  assign status_reg_o   = sr_out_q;
  assign insn_address_o = insn_out_q;
  assign error_o        = err_out_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import scc_pkg::*;

  localparam logic [15:0] FLG_C = 16'h0001;
  localparam logic [15:0] FLG_Z = 16'h0002;
  localparam logic [15:0] FLG_N = 16'h0004;
  localparam logic [15:0] FLG_V = 16'h0100;

  localparam logic [1:0] AM_REG = 2'd0;
  localparam logic [1:0] AM_IDX = 2'd1;
  localparam logic [1:0] AM_IND = 2'd2;
  localparam logic [1:0] AM_INC = 2'd3;

  localparam logic [2:0] JC_NE = 3'd0;
  localparam logic [2:0] JC_EQ = 3'd1;
  localparam logic [2:0] JC_NC = 3'd2;
  localparam logic [2:0] JC_C  = 3'd3;
  localparam logic [2:0] JC_N  = 3'd4;
  localparam logic [2:0] JC_GE = 3'd5;
  localparam logic [2:0] JC_L  = 3'd6;

  typedef struct {
    logic [15:0] pc;
    logic [15:0] sr;
    logic [15:0] ia;
    logic        err;
  } core_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = 2'd0;
  logic [15:0] address_i = 16'd0;
  logic [15:0] data_i = 16'd0;
  logic [3:0]  reg_index_i = 4'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] pc_o;
  logic [15:0] status_reg_o;
  logic [15:0] insn_address_o;
  logic        error_o;

  sixteen_bit_cpu_core_step dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .mode_i(mode_i), .address_i(address_i), .data_i(data_i), .reg_index_i(reg_index_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .pc_o(pc_o), .status_reg_o(status_reg_o), .insn_address_o(insn_address_o),
    .error_o(error_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the core state
  logic [7:0]  mem_img [0:65535];
  logic [15:0] regs [0:15];
  logic [15:0] last_insn_addr;

  core_result_t pending_q[$];
  int unsigned  fail_cnt = 0;
  int unsigned  hold_left = 0;
  int unsigned  stall_left = 0;
  bit           calm = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rd_w(input logic [15:0] a);
    logic [15:0] a1;
    a1 = a + 16'd1;
    return {mem_img[a1], mem_img[a]};
  endfunction

  function automatic void wr_w(input logic [15:0] a, input logic [31:0] v);
    logic [15:0] a1;
    a1 = a + 16'd1;
    mem_img[a] = v[7:0];
    mem_img[a1] = v[15:8];
  endfunction

  function automatic void set_flags(input bit c, input bit z, input bit n, input bit v);
    logic [15:0] s;
    s = regs[REG_SR] & ~(FLG_C | FLG_Z | FLG_N | FLG_V);
    if (c) s |= FLG_C;
    if (z) s |= FLG_Z;
    if (n) s |= FLG_N;
    if (v) s |= FLG_V;
    regs[REG_SR] = s;
  endfunction

  function automatic logic [31:0] fetch_opnd(input logic [1:0] am, input logic [3:0] r,
                                             input bit byte_op, output logic [15:0] ea,
                                             output bit to_mem);
    logic [31:0] mask;
    logic [15:0] a, at, ext;
    mask = byte_op ? 32'hff : 32'hffff;
    ea = 16'd0;
    to_mem = 1'b0;
    a = 16'd0;
    case (am)
      AM_REG: begin
        if (r == REG_CG) return 32'd0;
        return {16'd0, regs[r]} & mask;
      end
      AM_IDX: begin
        if (r == REG_CG) return 32'd1;
        at = regs[REG_PC];
        ext = rd_w(at);
        regs[REG_PC] = at + 16'd2;
        if (r == REG_SR) a = ext;
        else if (r == REG_PC) a = ext + at;
        else a = ext + regs[r];
      end
      AM_IND: begin
        if (r == REG_SR) return 32'd4;
        if (r == REG_CG) return 32'd2;
        a = regs[r];
      end
      default: begin
        if (r == REG_SR) return 32'd8;
        if (r == REG_CG) return mask;
        a = regs[r];
        regs[r] = a + ((byte_op && r > 4'd1) ? 16'd1 : 16'd2);
      end
    endcase
    ea = a;
    to_mem = 1'b1;
    return {16'd0, rd_w(a)} & mask;
  endfunction

  function automatic void store_opnd(input logic [1:0] am, input logic [3:0] r,
                                     input bit byte_op, input logic [15:0] ea,
                                     input bit to_mem, input logic [31:0] v);
    if (am == AM_REG) regs[r] = byte_op ? {8'd0, v[7:0]} : v[15:0];
    else if (to_mem) begin
      if (byte_op) mem_img[ea] = v[7:0];
      else wr_w(ea, v);
    end
  endfunction

  function automatic void do_double(input logic [15:0] ins);
    logic [3:0]  op, sreg, dreg;
    logic [1:0]  as_m, ad_m;
    bit          byte_op, tm, dtm, cf;
    logic [31:0] mask, msb, src, dst, res, s, cin, d, carry;
    logic [15:0] ea, dummy;
    op = ins[15:12];
    sreg = ins[11:8];
    dreg = ins[3:0];
    as_m = ins[5:4];
    ad_m = {1'b0, ins[7]};
    byte_op = ins[6];
    mask = byte_op ? 32'hff : 32'hffff;
    msb = byte_op ? 32'h80 : 32'h8000;
    src = fetch_opnd(as_m, sreg, byte_op, dummy, dtm);
    dst = fetch_opnd(ad_m, dreg, byte_op, ea, tm);
    res = 32'd0;
    cf = (regs[REG_SR] & FLG_C) != 0;
    case (op)
      DO_MOV: res = src;
      DO_ADD, DO_ADDC, DO_SUBC, DO_SUB, DO_CMP: begin
        s = (op >= DO_SUBC) ? (~src & mask) : src;
        cin = (op == DO_ADDC || op == DO_SUBC) ? {31'd0, cf} : ((op >= DO_SUB) ? 32'd1 : 32'd0);
        res = s + dst + cin;
        set_flags((res & (msb << 1)) != 0, (res & mask) == 0, (res & msb) != 0,
                  ((~(s ^ dst)) & (s ^ res) & msb) != 0);
      end
      DO_DADD: begin
        carry = {31'd0, cf};
        for (int i = 0; i < (byte_op ? 2 : 4); i++) begin
          d = ((src >> (4 * i)) & 32'hf) + ((dst >> (4 * i)) & 32'hf) + carry;
          if (d > 32'd9) begin
            d += 32'd6;
            carry = 32'd1;
          end else begin
            carry = 32'd0;
          end
          res |= (d & 32'hf) << (4 * i);
        end
        set_flags(carry != 0, (res & mask) == 0, (res & msb) != 0, 1'b0);
      end
      DO_BIT, DO_AND: begin
        res = src & dst;
        set_flags((res & mask) != 0, (res & mask) == 0, (res & msb) != 0, 1'b0);
      end
      DO_BIC: res = dst & ~src;
      DO_BIS: res = dst | src;
      default: begin
        res = dst ^ src;
        set_flags((res & mask) != 0, (res & mask) == 0, (res & msb) != 0,
                  (src & dst & msb) != 0);
      end
    endcase
    if (op != DO_CMP && op != DO_BIT) store_opnd(ad_m, dreg, byte_op, ea, tm, res & mask);
  endfunction

  function automatic void do_jump(input logic [15:0] ins);
    logic [15:0] s, off;
    bit n, v, take;
    s = regs[REG_SR];
    n = (s & FLG_N) != 0;
    v = (s & FLG_V) != 0;
    off = {5'd0, ins[9:0], 1'b0};
    if (off[10]) off |= 16'hf800;
    case (ins[12:10])
      JC_NE:   take = (s & FLG_Z) == 0;
      JC_EQ:   take = (s & FLG_Z) != 0;
      JC_NC:   take = (s & FLG_C) == 0;
      JC_C:    take = (s & FLG_C) != 0;
      JC_N:    take = n;
      JC_GE:   take = (n == v);
      JC_L:    take = (n != v);
      default: take = 1'b1;
    endcase
    if (take) regs[REG_PC] = regs[REG_PC] + off;
  endfunction

  function automatic void do_single(input logic [15:0] ins);
    logic [2:0]  code;
    logic [1:0]  am;
    logic [3:0]  r;
    bit          byte_op, tm;
    logic [31:0] mask, msb, src, res;
    logic [15:0] ea;
    code = ins[9:7];
    am = ins[5:4];
    r = ins[3:0];
    byte_op = ins[6];
    mask = byte_op ? 32'hff : 32'hffff;
    msb = byte_op ? 32'h80 : 32'h8000;
    src = fetch_opnd(am, r, byte_op, ea, tm);
    res = 32'd0;
    case (code)
      SC_RRC, SC_RRA: begin
        res = (src >> 1) & ~msb;
        if (code == SC_RRC) begin
          if ((regs[REG_SR] & FLG_C) != 0) res |= msb;
        end else begin
          res |= src & msb;
        end
        set_flags(src[0], (res & mask) == 0, (res & msb) != 0, 1'b0);
      end
      SC_SWPB: res = {16'd0, src[7:0], src[15:8]};
      SC_SXT: begin
        res = {24'd0, src[7:0]};
        if (src[7]) res |= 32'hff00;
        set_flags((res & mask) != 0, (res & mask) == 0, src[7], 1'b0);
      end
      SC_PUSH: begin
        regs[REG_SP] = regs[REG_SP] - 16'd2;
        wr_w(regs[REG_SP], src);
        return;
      end
      SC_CALL: begin
        regs[REG_SP] = regs[REG_SP] - 16'd2;
        wr_w(regs[REG_SP], {16'd0, regs[REG_PC]});
        regs[REG_PC] = src[15:0];
        return;
      end
      default: begin
        regs[REG_SR] = rd_w(regs[REG_SP]);
        regs[REG_SP] = regs[REG_SP] + 16'd2;
        regs[REG_PC] = rd_w(regs[REG_SP]);
        regs[REG_SP] = regs[REG_SP] + 16'd2;
        return;
      end
    endcase
    store_opnd(am, r, byte_op, ea, tm, res & mask);
  endfunction

  // returns 0 on an invalid opcode
  function automatic bit exec_insn();
    logic [15:0] at, ins;
    at = regs[REG_PC];
    ins = rd_w(at);
    last_insn_addr = at;
    if (ins < 16'h2000) begin
      if ((ins & 16'hfc00) != 16'h1000 || ins[9:7] == 3'd7) return 1'b0;
      regs[REG_PC] = at + 16'd2;
      do_single(ins);
    end else begin
      regs[REG_PC] = at + 16'd2;
      if (ins >= 16'h4000) do_double(ins);
      else do_jump(ins);
    end
    return 1'b1;
  endfunction

  function automatic core_result_t predict_core(input mode_e m, input logic [15:0] a,
                                                input logic [15:0] d, input logic [3:0] ri);
    core_result_t res;
    bit ok;
    ok = 1'b1;
    case (m)
      MODE_LOAD:   mem_img[a] = d[7:0];
      MODE_SETREG: regs[ri] = d;
      MODE_RESET: begin
        for (int i = 0; i < REG_COUNT; i++) regs[i] = 16'd0;
        regs[REG_PC] = rd_w(RESET_VECTOR);
      end
      default: ok = exec_insn();
    endcase
    res.pc = regs[REG_PC];
    res.sr = regs[REG_SR];
    res.ia = last_insn_addr;
    res.err = !ok;
    return res;
  endfunction

  task automatic send_req(input mode_e m, input logic [15:0] a, input logic [15:0] d,
                          input logic [3:0] ri);
    int unsigned g;
    mode_i <= m;
    address_i <= a;
    data_i <= d;
    reg_index_i <= ri;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_q.push_back(predict_core(m, a, d, ri));
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic load_word(input logic [15:0] a, input logic [15:0] w);
    send_req(MODE_LOAD, a, {8'($urandom), w[7:0]}, 4'($urandom));
    send_req(MODE_LOAD, a + 16'd1, {8'($urandom), w[15:8]}, 4'($urandom));
  endtask

  task automatic run_at(input logic [15:0] a, input logic [15:0] w0, input logic [15:0] w1,
                        input logic [15:0] w2);
    load_word(a, w0);
    load_word(a + 16'd2, w1);
    load_word(a + 16'd4, w2);
    send_req(MODE_SETREG, 16'($urandom), a, REG_PC);
    send_req(MODE_EXEC, 16'($urandom), 16'($urandom), 4'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_insn();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return {4'($urandom_range(4, 15)), 12'($urandom)};
    if (r < 75) return {6'b000100, 3'($urandom_range(0, 6)), 7'($urandom)};
    if (r < 90) return {3'b001, 13'($urandom)};
    return 16'($urandom);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    core_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (pc_o !== exp_r.pc) begin
          $error("pc: expected %h, got %h", exp_r.pc, pc_o);
          fail_cnt++;
        end
        if (status_reg_o !== exp_r.sr) begin
          $error("status_reg: expected %h, got %h", exp_r.sr, status_reg_o);
          fail_cnt++;
        end
        if (insn_address_o !== exp_r.ia) begin
          $error("insn_address: expected %h, got %h", exp_r.ia, insn_address_o);
          fail_cnt++;
        end
        if (error_o !== exp_r.err) begin
          $error("error: expected %b, got %b", exp_r.err, error_o);
          fail_cnt++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (!calm) stall_left <= pick_gap();
    end
  end

  task automatic test_load_and_setreg();
    send_req(MODE_LOAD, 16'h0000, 16'hff00, 4'h0);
    send_req(MODE_LOAD, 16'hffff, 16'h00ff, 4'hf);
    send_req(MODE_SETREG, 16'hffff, 16'hffff, 4'hf);
    send_req(MODE_SETREG, 16'h0000, 16'h0000, 4'h0);
  endtask

  task automatic test_core_reset();
    load_word(RESET_VECTOR, 16'h4400);
    send_req(MODE_RESET, 16'hffff, 16'hffff, 4'hf);
  endtask

  task automatic test_directed_insns();
    send_req(MODE_SETREG, 16'd0, 16'h0200, REG_SP);
    run_at(16'h4400, 16'h4035, 16'h1234, 16'h0000);  // mov #imm, r5
    run_at(16'h4400, 16'ha506, 16'h0000, 16'h0000);  // decimal add r5 -> r6
    run_at(16'h4400, 16'h4012, 16'h0010, 16'h0000);  // mov pc-relative, sr
    run_at(16'hfffe, 16'h5392, 16'h0300, 16'h0000);  // add #1 to absolute, wraps
    run_at(16'h4400, 16'h1300, 16'h0000, 16'h0000);  // return from interrupt
    run_at(16'h4400, 16'h3fff, 16'h0000, 16'h0000);  // jump always, back
    run_at(16'h4400, 16'h0000, 16'h0000, 16'h0000);  // invalid, low range
    run_at(16'h4400, 16'h1380, 16'h0000, 16'h0000);  // invalid, single-op gap
  endtask

  task automatic test_random_programs();
    logic [15:0] base;
    repeat (70) begin
      base = 16'($urandom);
      load_word(base, rand_insn());
      load_word(base + 16'd2, 16'($urandom));
      load_word(base + 16'd4, 16'($urandom));
      repeat ($urandom_range(0, 2))
        send_req(MODE_SETREG, 16'($urandom), 16'($urandom), 4'($urandom_range(1, 15)));
      send_req(MODE_SETREG, 16'($urandom), base, REG_PC);
      repeat ($urandom_range(1, 2))
        send_req(MODE_EXEC, 16'($urandom), 16'($urandom), 4'($urandom));
    end
  endtask

  task automatic test_noise();
    repeat (100)
      send_req(mode_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 4'($urandom));
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_left = 400;
    calm = 1'b1;
    repeat (30)
      send_req(mode_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 4'($urandom));
    // pause until the pipe is empty, then run without gaps for a while
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (40) send_req(MODE_EXEC, 16'($urandom), 16'($urandom), 4'($urandom));
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 65536; i++) mem_img[i] = 8'hff;
    for (int i = 0; i < REG_COUNT; i++) regs[i] = 16'hffff;
    last_insn_addr = 16'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_and_setreg();
    test_core_reset();
    test_directed_insns();
    test_random_programs();
    test_backpressure();
    test_noise();
    test_random_programs();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #36000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/scc_pkg.sv
rtl/scc_ram.sv
rtl/scc_ctrl.sv
rtl/scc_dp.sv
rtl/sixteen_bit_cpu_core_step.sv
tb/tb_top.sv
